// ===== hdl/pdv_pkg.sv =====
`default_nettype none
package pdv_pkg;

   // Number of proximity samples in the moving average.
   localparam int WINDOW = 10;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   localparam int SAMPLE_W  = 16;
   localparam int BATTERY_W = 10;
   localparam int SUM_W     = 20;
   localparam int COUNT_W   = 8;
   localparam int TIMER_W   = 16;

   // Floor division by WINDOW is done as a multiply by a rounded-up reciprocal.
   // With a sum below 2**SUM_W and WINDOW up to 16, this shift keeps it exact.
   localparam int      RECIP_SHIFT = SUM_W + 5;
   localparam int      RECIP_W     = RECIP_SHIFT + 1;
   localparam longint  RECIP       = ((64'd1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
   localparam int      PROD_W      = SUM_W + RECIP_W;

   // Battery must lie strictly within this distance of the reference to open.
   localparam int BAT_WINDOW = 80;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HIGH_THRESHOLD    = 3'd0,
      CSR_LOW_THRESHOLD     = 3'd1,
      CSR_ARRIVE_COUNT      = 3'd2,
      CSR_LEAVE_COUNT       = 3'd3,
      CSR_STAY_LIMIT        = 3'd4,
      CSR_BATTERY_REFERENCE = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PRES_IDLE = 2'd0,
      PRES_HERE = 2'd1,
      PRES_CUT  = 2'd2
   } presence_type;

   typedef enum logic [1:0] {
      PULSE_NONE  = 2'd0,
      PULSE_OPEN  = 2'd1,
      PULSE_CLOSE = 2'd2
   } pulse_type;

   // One accepted tick as it enters the averaging pipeline.
   typedef struct packed {
      logic                 valid;
      logic [SAMPLE_W-1:0]  sample;
      logic [BATTERY_W-1:0] battery;
   } sample_type;

   // One tick leaving the averaging pipeline.
   typedef struct packed {
      logic                 valid;
      logic [SAMPLE_W-1:0]  average;
      logic [BATTERY_W-1:0] battery;
   } avg_type;

endpackage
`default_nettype wire

// ===== hdl/pdv_avg.sv =====
`default_nettype none
module pdv_avg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire pdv_pkg::sample_type smp,
   output pdv_pkg::avg_type         avg
);

   localparam int SW = pdv_pkg::SLOT_W;

   // Sample window storage and per-entry written flags.
   logic [pdv_pkg::SAMPLE_W-1:0] win_mem [pdv_pkg::WINDOW];
   logic [pdv_pkg::WINDOW-1:0]   vld_ff;
   logic [SW-1:0]                slot_ff;

   // Read stage.
   logic                          b_valid_ff;
   logic [pdv_pkg::SAMPLE_W-1:0]  b_sample_ff;
   logic [pdv_pkg::BATTERY_W-1:0] b_bat_ff;
   logic [SW-1:0]                 b_slot_ff;
   logic [pdv_pkg::SAMPLE_W-1:0]  rd_data_ff;
   logic                          rd_hit_ff;
   logic                          fwd_ff;
   logic [pdv_pkg::SAMPLE_W-1:0]  fwd_data_ff;

   // Sum stage and multiply stage.
   logic [pdv_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic                          c_valid_ff;
   logic [pdv_pkg::BATTERY_W-1:0] c_bat_ff;
   logic [pdv_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic                          d_valid_ff;
   logic [pdv_pkg::BATTERY_W-1:0] d_bat_ff;

   logic                          rd_en, wr_en;
   logic [pdv_pkg::SAMPLE_W-1:0]  old_sample;
   logic [SW-1:0]                 slot_in;
   logic [pdv_pkg::RECIP_W-1:0]   recip_c;

   assign rd_en   = adv & smp.valid;
   assign wr_en   = adv & b_valid_ff;
   assign recip_c = pdv_pkg::RECIP_W'(pdv_pkg::RECIP);
   assign slot_in = (slot_ff == SW'(pdv_pkg::WINDOW - 1)) ? '0 : slot_ff + 1'b1;

   // The sample leaving the window: a same-slot write in flight wins,
   // and a slot never written reads as zero.
   always_comb begin
      if (fwd_ff) begin
         old_sample = fwd_data_ff;
      end else if (rd_hit_ff) begin
         old_sample = rd_data_ff;
      end else begin
         old_sample = '0;
      end
      sum_in  = sum_ff - {{(pdv_pkg::SUM_W - pdv_pkg::SAMPLE_W){1'b0}}, old_sample}
                       + {{(pdv_pkg::SUM_W - pdv_pkg::SAMPLE_W){1'b0}}, b_sample_ff};
      prod_in = {{pdv_pkg::RECIP_W{1'b0}}, sum_ff} * {{pdv_pkg::SUM_W{1'b0}}, recip_c};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         win_mem[b_slot_ff] <= b_sample_ff;
      end
      if (rd_en) begin
         rd_data_ff <= win_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         b_sample_ff <= smp.sample;
         b_bat_ff    <= smp.battery;
         b_slot_ff   <= slot_ff;
         rd_hit_ff   <= vld_ff[slot_ff];
         fwd_ff      <= wr_en && (b_slot_ff == slot_ff);
         fwd_data_ff <= b_sample_ff;
      end
      if (adv) begin
         c_bat_ff <= b_bat_ff;
         prod_ff  <= prod_in;
         d_bat_ff <= c_bat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         slot_ff    <= '0;
         sum_ff     <= '0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            slot_ff <= slot_in;
         end
         if (wr_en) begin
            vld_ff[b_slot_ff] <= 1'b1;
            sum_ff            <= sum_in;
         end
         if (adv) begin
            b_valid_ff <= smp.valid;
            c_valid_ff <= b_valid_ff;
            d_valid_ff <= c_valid_ff;
         end
      end
   end

   assign avg.valid   = d_valid_ff;
   assign avg.average = prod_ff[pdv_pkg::RECIP_SHIFT +: pdv_pkg::SAMPLE_W];
   assign avg.battery = d_bat_ff;

endmodule
`default_nettype wire

// ===== hdl/presence_detect_valve_control.sv =====
`default_nettype none
// Channel | Direction | Handshake           | Payload
// req     | in        | req_tvalid/tready   | tdata: ps_sample[15:0], battery_sample[25:16],
//         |           |                     |        zero fill [31:26]
// rsp     | out       | rsp_tvalid/tready   | tdata: average, presence, arrived, departed,
//         |           |                     |        valve_pulse, valve_open, standby_request
// csr     | in        | csr_wr_en           | csr_index selects register, csr_wdata value
//
// One tick transfer is accepted every clock cycle while the output is not stalled.
// Each tick passes through the window memory read, the running sum register and the
// reciprocal multiply that forms the floor average, followed by the presence update.
// Reset is synchronous and active high; the window needs no clearing pass because each
// slot carries a written flag that reset clears, and an unwritten slot reads as zero.
// When rsp_tready is low with a result held, the whole pipeline holds and req_tready
// drops in the same cycle.
module presence_detect_valve_control (
   input  wire logic        clock,
   input  wire logic        reset,
   // ps_sample [15:0], battery_sample [25:16], zero [31:26]
   input  wire logic [31:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // average [15:0], presence [17:16], arrived [18], departed [19],
   // valve_pulse [21:20], valve_open [22], standby_request [23]
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_wr_en,
   input  wire logic [pdv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pdv_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic [15:0] high_thr_ff, low_thr_ff, stay_limit_ff;
   logic [7:0]  arrive_cnt_ff, leave_cnt_ff;
   logic [9:0]  bat_ref_ff;

   // Presence state.
   pdv_pkg::presence_type presence_ff, presence_in;
   logic [pdv_pkg::COUNT_W-1:0] arr_ctr_ff, arr_ctr_in;
   logic [pdv_pkg::COUNT_W-1:0] lv_ctr_ff, lv_ctr_in;
   logic [pdv_pkg::TIMER_W-1:0] stay_ff, stay_in;
   logic                        first_ff, first_in;
   logic                        valve_ff, valve_in;

   // Output register.
   logic                 rsp_valid_ff;
   logic [23:0]          rsp_data_ff, rsp_data_in;

   logic                 adv;
   logic                 arrived, departed, standby, leaving;
   pdv_pkg::pulse_type   pulse;
   logic signed [10:0]   bat_diff;
   logic [10:0]          bat_abs;

   pdv_pkg::sample_type  smp;
   pdv_pkg::avg_type     avg;

   // The pipeline moves whenever the output register is empty or being drained.
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   assign smp.valid   = req_tvalid;
   assign smp.sample  = req_tdata[15:0];
   assign smp.battery = req_tdata[25:16];

   pdv_avg u_avg (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .smp   (smp),
      .avg   (avg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff   <= 16'hFFFF;
         low_thr_ff    <= 16'h0000;
         arrive_cnt_ff <= 8'd4;
         leave_cnt_ff  <= 8'd8;
         stay_limit_ff <= 16'd1200;
         bat_ref_ff    <= 10'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            pdv_pkg::CSR_HIGH_THRESHOLD:    high_thr_ff   <= csr_wdata;
            pdv_pkg::CSR_LOW_THRESHOLD:     low_thr_ff    <= csr_wdata;
            pdv_pkg::CSR_ARRIVE_COUNT:      arrive_cnt_ff <= csr_wdata[7:0];
            pdv_pkg::CSR_LEAVE_COUNT:       leave_cnt_ff  <= csr_wdata[7:0];
            pdv_pkg::CSR_STAY_LIMIT:        stay_limit_ff <= csr_wdata;
            pdv_pkg::CSR_BATTERY_REFERENCE: bat_ref_ff    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // Battery distance from its reference, used for the first-arrival open.
   assign bat_diff = $signed({1'b0, bat_ref_ff}) - $signed({1'b0, avg.battery});
   assign bat_abs  = bat_diff[10] ? 11'(-bat_diff) : 11'(bat_diff);

   // Presence update for one tick. The steps run in order: arrival counting
   // while idle, leave counting while present, the standby check against the
   // valve state from before this tick, present-state actions, then departure.
   always_comb begin
      presence_in = presence_ff;
      arr_ctr_in  = arr_ctr_ff;
      lv_ctr_in   = lv_ctr_ff;
      stay_in     = stay_ff;
      first_in    = first_ff;
      valve_in    = valve_ff;
      arrived     = 1'b0;
      departed    = 1'b0;
      leaving     = 1'b0;
      pulse       = pdv_pkg::PULSE_NONE;

      if ((avg.average >= high_thr_ff) && (presence_in == pdv_pkg::PRES_IDLE)) begin
         arr_ctr_in = arr_ctr_in + 1'b1;
         lv_ctr_in  = '0;
         if (arr_ctr_in >= arrive_cnt_ff) begin
            arr_ctr_in  = '0;
            first_in    = 1'b1;
            presence_in = pdv_pkg::PRES_HERE;
            arrived     = 1'b1;
         end
      end

      if ((avg.average <= low_thr_ff) &&
          ((presence_in == pdv_pkg::PRES_HERE) || (presence_in == pdv_pkg::PRES_CUT))) begin
         lv_ctr_in  = lv_ctr_in + 1'b1;
         arr_ctr_in = '0;
         if (lv_ctr_in >= leave_cnt_ff) begin
            lv_ctr_in = '0;
            leaving   = 1'b1;
         end
      end

      standby = (avg.average <= low_thr_ff) && !valve_ff;

      if (!leaving && (presence_in == pdv_pkg::PRES_HERE)) begin
         stay_in = stay_in + 1'b1;
         if (first_in) begin
            first_in = 1'b0;
            if (bat_abs < 11'(pdv_pkg::BAT_WINDOW)) begin
               valve_in = 1'b1;
               pulse    = pdv_pkg::PULSE_OPEN;
            end
         end
         // A timeout in the same tick as the open overrides it.
         if (stay_in >= stay_limit_ff) begin
            valve_in    = 1'b0;
            pulse       = pdv_pkg::PULSE_CLOSE;
            presence_in = pdv_pkg::PRES_CUT;
         end
      end

      // Departure always closes, even when the valve is already closed.
      if (leaving) begin
         stay_in     = '0;
         presence_in = pdv_pkg::PRES_IDLE;
         valve_in    = 1'b0;
         pulse       = pdv_pkg::PULSE_CLOSE;
         standby     = 1'b1;
         departed    = 1'b1;
      end

      rsp_data_in = {standby, valve_in, pulse, departed, arrived, presence_in, avg.average};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presence_ff  <= pdv_pkg::PRES_IDLE;
         arr_ctr_ff   <= '0;
         lv_ctr_ff    <= '0;
         stay_ff      <= '0;
         first_ff     <= 1'b0;
         valve_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= avg.valid;
         if (avg.valid) begin
            presence_ff <= presence_in;
            arr_ctr_ff  <= arr_ctr_in;
            lv_ctr_ff   <= lv_ctr_in;
            stay_ff     <= stay_in;
            first_ff    <= first_in;
            valve_ff    <= valve_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && avg.valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hdl/pdv_checker.sv =====
`default_nettype none
module pdv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);

   // A held result keeps its contents until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A stalled output stops new ticks from entering.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

   // A departure leaves the detector idle with the valve closed and standby asked.
   a_departure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19] |->
         (rsp_tdata[17:16] == pdv_pkg::PRES_IDLE) &&
         (rsp_tdata[21:20] == pdv_pkg::PULSE_CLOSE) &&
         !rsp_tdata[22] && rsp_tdata[23])
      else $error("departure result inconsistent");

   // An open pulse only happens while present, and leaves the valve open.
   a_open_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[21:20] == pdv_pkg::PULSE_OPEN) |->
         rsp_tdata[22] && (rsp_tdata[17:16] == pdv_pkg::PRES_HERE))
      else $error("open pulse without presence");

   // An arrival without a departure in the same tick is never idle.
   a_arrival: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18] && !rsp_tdata[19] |->
         (rsp_tdata[17:16] != pdv_pkg::PRES_IDLE))
      else $error("arrival left detector idle");

endmodule

bind presence_detect_valve_control pdv_checker u_pdv_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;

   // The run is bounded by this many clock cycles.
   localparam int CYCLE_LIMIT = 200_000;
   // Settle time before a register write and at the end of the run.
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 231;
   // Phase in which the receiver holds off, and phase in which the sender waits
   // for the block to drain completely.
   localparam int HOLD_PHASE = 0;
   localparam int DRAIN_PHASE = 4;
   localparam int HOLD_CYCLES = 80;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {SEG_HIGH, SEG_LOW, SEG_NOISE} segment_kind_type;
   typedef enum int {ROW_SETTINGS, ROW_TICK} row_kind_type;

   typedef struct {
      logic [15:0] high_thr;
      logic [15:0] low_thr;
      logic [7:0]  arrive_need;
      logic [7:0]  leave_need;
      logic [15:0] stay_max;
      logic [9:0]  bat_ref;
   } valve_settings_type;

   // One result of one tick, field by field, as it leaves on rsp_tdata.
   typedef struct {
      logic [15:0]           average;
      pdv_pkg::presence_type presence;
      logic                  arrived;
      logic                  departed;
      pdv_pkg::pulse_type    pulse;
      logic                  valve_open;
      logic                  standby;
   } tick_outcome_type;

   // One row of the directed table. A tick row may carry a typed-in result;
   // otherwise the outcome model provides the expectation.
   typedef struct {
      row_kind_type       kind;
      valve_settings_type settings;
      logic [15:0]        ps;
      logic [9:0]         bat;
      bit                 typed;
      tick_outcome_type   outcome;
   } directed_row_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Block ports. Every input holds a known value from time zero.
   logic [31:0]            req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic                   csr_wr_en  = 1'b0;
   pdv_pkg::csr_index_type csr_index  = pdv_pkg::CSR_HIGH_THRESHOLD;
   logic [pdv_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   presence_detect_valve_control u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Register copy used by the outcome model. It starts at the reset values and
   // follows every write that the testbench makes.
   valve_settings_type cfg = '{high_thr: 16'hFFFF, low_thr: 16'd0, arrive_need: 8'd4,
                               leave_need: 8'd8, stay_max: 16'd1200, bat_ref: 10'd0};

   // State of the outcome model, reset to the block's reset state.
   logic [15:0]           window_copy [pdv_pkg::WINDOW] = '{default: 16'd0};
   logic [19:0]           window_total  = '0;
   int                    next_slot     = 0;
   pdv_pkg::presence_type room_state    = pdv_pkg::PRES_IDLE;
   logic [7:0]            arrive_tally  = '0;
   logic [7:0]            leave_tally   = '0;
   logic [15:0]           stay_ticks    = '0;
   bit                    fresh_arrival = 1'b0;
   bit                    valve_is_open = 1'b0;

   // Expected results in the order their ticks were accepted.
   tick_outcome_type awaited_outcomes [$];
   tick_outcome_type blank_outcome;
   directed_row_type directed_rows [$];

   idle_mode_type idle_mode = IDLE_NONE;
   bit            long_hold_pending = 1'b0;
   int            cycle_count = 0;
   int            mismatch_count = 0;

   // Works out the result of one tick and advances the model state. The order
   // matters: window, arrival, leaving, standby on the old valve state, the
   // present-state actions, and last the departure close.
   task automatic compute_tick_outcome(input logic [15:0] ps, input logic [9:0] bat,
                                       output tick_outcome_type res);
      logic [15:0] avg;
      bit          leaving;
      int          bat_gap;
      res = '{average: 16'd0, presence: pdv_pkg::PRES_IDLE, arrived: 1'b0,
              departed: 1'b0, pulse: pdv_pkg::PULSE_NONE, valve_open: 1'b0,
              standby: 1'b0};
      leaving = 1'b0;

      window_total = window_total - window_copy[next_slot] + ps;
      window_copy[next_slot] = ps;
      next_slot = (next_slot == pdv_pkg::WINDOW - 1) ? 0 : next_slot + 1;
      avg = 16'(window_total / 20'(pdv_pkg::WINDOW));

      if (avg >= cfg.high_thr && room_state == pdv_pkg::PRES_IDLE) begin
         arrive_tally = arrive_tally + 8'd1;
         leave_tally = '0;
         if (arrive_tally >= cfg.arrive_need) begin
            arrive_tally = '0;
            fresh_arrival = 1'b1;
            room_state = pdv_pkg::PRES_HERE;
            res.arrived = 1'b1;
         end
      end
      if (avg <= cfg.low_thr && room_state != pdv_pkg::PRES_IDLE) begin
         leave_tally = leave_tally + 8'd1;
         arrive_tally = '0;
         if (leave_tally >= cfg.leave_need) begin
            leave_tally = '0;
            leaving = 1'b1;
         end
      end
      if (avg <= cfg.low_thr && !valve_is_open)
         res.standby = 1'b1;

      if (!leaving && room_state == pdv_pkg::PRES_HERE) begin
         stay_ticks = stay_ticks + 16'd1;
         if (fresh_arrival) begin
            // The valve opens only on a battery reading close to the reference.
            fresh_arrival = 1'b0;
            bat_gap = int'(cfg.bat_ref) - int'(bat);
            if (bat_gap < 0)
               bat_gap = -bat_gap;
            if (bat_gap < pdv_pkg::BAT_WINDOW) begin
               valve_is_open = 1'b1;
               res.pulse = pdv_pkg::PULSE_OPEN;
            end
         end
         if (stay_ticks >= cfg.stay_max) begin
            valve_is_open = 1'b0;
            res.pulse = pdv_pkg::PULSE_CLOSE;
            room_state = pdv_pkg::PRES_CUT;
         end
      end
      if (leaving) begin
         stay_ticks = '0;
         room_state = pdv_pkg::PRES_IDLE;
         valve_is_open = 1'b0;
         res.pulse = pdv_pkg::PULSE_CLOSE;
         res.standby = 1'b1;
         res.departed = 1'b1;
      end

      res.average = avg;
      res.presence = room_state;
      res.valve_open = valve_is_open;
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   // Offers one tick transfer, with random idle cycles ahead of it in the sender
   // idling phases. The call starts and ends at a falling edge. The expectation is
   // queued at the rising edge that accepts the transfer.
   task automatic push_tick(input logic [15:0] ps, input logic [9:0] bat,
                            input bit typed, input tick_outcome_type typed_outcome);
      tick_outcome_type predicted;
      while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 47) ||
             (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 10)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, bat, ps};
      do
         @(posedge clock);
      while (!req_tready);
      compute_tick_outcome(ps, bat, predicted);
      awaited_outcomes.push_back(typed ? typed_outcome : predicted);
      @(negedge clock);
   endtask

   // Lowers the request valid and waits at falling edges until every expected
   // result has been seen. Time always advances, even with nothing awaited.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (awaited_outcomes.size() != 0);
   endtask

   // Writes all six registers on consecutive cycles while the block is idle.
   // The write enable stays high across the burst and drops once after it.
   task automatic apply_settings(input valve_settings_type s);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      for (int i = 0; i < 6; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= pdv_pkg::csr_index_type'(i);
         case (pdv_pkg::csr_index_type'(i))
            pdv_pkg::CSR_HIGH_THRESHOLD:    csr_wdata <= s.high_thr;
            pdv_pkg::CSR_LOW_THRESHOLD:     csr_wdata <= s.low_thr;
            pdv_pkg::CSR_ARRIVE_COUNT:      csr_wdata <= 16'(s.arrive_need);
            pdv_pkg::CSR_LEAVE_COUNT:       csr_wdata <= 16'(s.leave_need);
            pdv_pkg::CSR_STAY_LIMIT:        csr_wdata <= s.stay_max;
            pdv_pkg::CSR_BATTERY_REFERENCE: csr_wdata <= 16'(s.bat_ref);
            default:                        csr_wdata <= '0;
         endcase
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      cfg = s;
   endtask

   // High samples keep the average at or above the arrival threshold once the
   // window is full of them, and low samples keep it at or below the leave
   // threshold. Noise spans the whole field.
   function automatic logic [15:0] draw_sample(input segment_kind_type kind);
      case (kind)
         SEG_HIGH: return 16'($urandom_range(65535, cfg.high_thr));
         SEG_LOW:  return 16'($urandom_range(cfg.low_thr, 0));
         default:  return 16'($urandom_range(65535, 0));
      endcase
   endfunction

   // Half of the battery readings fall near the reference so that both sides
   // of the open window are exercised.
   function automatic logic [9:0] draw_battery();
      int b;
      if ($urandom_range(0, 1) == 0)
         return 10'($urandom_range(1023, 0));
      b = int'(cfg.bat_ref) + int'($urandom_range(0, 200)) - 100;
      if (b < 0)
         b = 0;
      if (b > 1023)
         b = 1023;
      return 10'(b);
   endfunction

   // Sends a run of one kind of sample. Halfway through the hold phase the
   // receiver is asked for a long hold-off, and halfway through the drain phase
   // the sender pauses until the block is empty.
   task automatic send_run(input segment_kind_type kind, input int run_len, input int phase,
                           input int budget, inout int sent);
      for (int k = 0; k < run_len && sent < budget; k++) begin
         push_tick(draw_sample(kind), draw_battery(), 1'b0, blank_outcome);
         sent++;
         if (sent == budget / 2) begin
            if (phase == HOLD_PHASE)
               long_hold_pending = 1'b1;
            if (phase == DRAIN_PHASE)
               wait_drained();
         end
      end
   endtask

   // Random part of one phase. Most of it is full visits: a high run long enough
   // to fill the window and reach the arrival count, often long enough to hit
   // the stay limit, then a low run long enough to declare departure. The rest
   // is short bursts of noise.
   task automatic run_phase(input int phase, input int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 9) < 8) begin
            send_run(SEG_HIGH, pdv_pkg::WINDOW + int'(cfg.arrive_need) +
                     int'($urandom_range(0, 40)), phase, budget, sent);
            send_run(SEG_LOW, pdv_pkg::WINDOW + int'(cfg.leave_need) +
                     int'($urandom_range(0, 6)), phase, budget, sent);
         end else begin
            send_run(SEG_NOISE, int'($urandom_range(1, 8)), phase, budget, sent);
         end
      end
   endtask

   // Register settings of each random phase. Phases 0, 2 and 3 take the extremes:
   // the strictest arrival and departure, thresholds that are met by every
   // average at once, and the two thresholds equal. Phases 4 and up are random.
   function automatic valve_settings_type phase_settings(input int phase);
      valve_settings_type s;
      case (phase)
         0: s = '{high_thr: 16'hFFFF, low_thr: 16'd0, arrive_need: 8'd255,
                  leave_need: 8'd255, stay_max: 16'hFFFF, bat_ref: 10'd1023};
         1: s = '{high_thr: 16'd30000, low_thr: 16'd5000, arrive_need: 8'd3,
                  leave_need: 8'd4, stay_max: 16'd20, bat_ref: 10'd500};
         2: s = '{high_thr: 16'd0, low_thr: 16'hFFFF, arrive_need: 8'd1,
                  leave_need: 8'd1, stay_max: 16'd1, bat_ref: 10'd0};
         3: s = '{high_thr: 16'd20000, low_thr: 16'd20000, arrive_need: 8'd2,
                  leave_need: 8'd2, stay_max: 16'd50, bat_ref: 10'($urandom_range(1023, 0))};
         default: begin
            s.high_thr = 16'($urandom_range(65535, 0));
            if ($urandom_range(0, 3) == 0)
               s.low_thr = 16'($urandom_range(65535, 0));
            else
               s.low_thr = 16'($urandom_range(s.high_thr, 0));
            s.arrive_need = 8'($urandom_range(8, 1));
            s.leave_need = 8'($urandom_range(8, 1));
            s.stay_max = 16'($urandom_range(300, 1));
            s.bat_ref = 10'($urandom_range(1023, 0));
         end
      endcase
      return s;
   endfunction

   function automatic void add_settings(input valve_settings_type s);
      directed_row_type row;
      row.kind = ROW_SETTINGS;
      row.settings = s;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_tick(input logic [15:0] ps, input logic [9:0] bat,
                                    input bit typed, input tick_outcome_type outcome);
      directed_row_type row;
      row.kind = ROW_TICK;
      row.ps = ps;
      row.bat = bat;
      row.typed = typed;
      row.outcome = outcome;
      directed_rows.push_back(row);
   endfunction

   // Receiver side. In the stalling phases rsp_tready drops at random. When a
   // long hold-off is asked for, it stays low for a counted stretch while the
   // sender keeps offering ticks, so the pipeline fills and req_tready falls.
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b1;
         end else if ((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 47) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 10)) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Result checker. Each result transfer is unpacked and compared field by
   // field with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      tick_outcome_type got;
      tick_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch($sformatf("result transfer 0x%06h with no tick waiting",
                                      rsp_tdata));
         end else begin
            want = awaited_outcomes.pop_front();
            got.average = rsp_tdata[15:0];
            got.presence = pdv_pkg::presence_type'(rsp_tdata[17:16]);
            got.arrived = rsp_tdata[18];
            got.departed = rsp_tdata[19];
            got.pulse = pdv_pkg::pulse_type'(rsp_tdata[21:20]);
            got.valve_open = rsp_tdata[22];
            got.standby = rsp_tdata[23];
            check_field("average", got.average, want.average);
            check_field("presence", got.presence, want.presence);
            check_field("arrived", got.arrived, want.arrived);
            check_field("departed", got.departed, want.departed);
            check_field("valve_pulse", got.pulse, want.pulse);
            check_field("valve_open", got.valve_open, want.valve_open);
            check_field("standby_request", got.standby, want.standby);
         end
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      blank_outcome = '{average: 16'd0, presence: pdv_pkg::PRES_IDLE, arrived: 1'b0,
                        departed: 1'b0, pulse: pdv_pkg::PULSE_NONE, valve_open: 1'b0,
                        standby: 1'b0};

      // Directed table. Under the reset settings the first two results can be
      // read off directly: an all-zero window gives a zero average and a
      // standby request with the valve closed, and one full-scale sample gives
      // an average of 65535 / 10 with no standby.
      add_tick(16'd0, 10'd0, 1'b1,
               '{average: 16'd0, presence: pdv_pkg::PRES_IDLE, arrived: 1'b0,
                 departed: 1'b0, pulse: pdv_pkg::PULSE_NONE, valve_open: 1'b0,
                 standby: 1'b1});
      add_tick(16'hFFFF, 10'd1023, 1'b1,
               '{average: 16'd6553, presence: pdv_pkg::PRES_IDLE, arrived: 1'b0,
                 departed: 1'b0, pulse: pdv_pkg::PULSE_NONE, valve_open: 1'b0,
                 standby: 1'b0});
      // Arrival threshold below the leave threshold: the same tick declares
      // arrival and departure, and the first-arrival mark is left set.
      add_settings('{high_thr: 16'd6000, low_thr: 16'd7000, arrive_need: 8'd1,
                     leave_need: 8'd1, stay_max: 16'd1, bat_ref: 10'd1023});
      repeat (2) add_tick(16'd0, 10'd1000, 1'b0, blank_outcome);
      // A normal visit: arrival after two ticks with the battery just inside the
      // window, an open pulse, the stay limit forcing a close, and departure
      // once the full-scale sample has left the window.
      add_settings('{high_thr: 16'd1000, low_thr: 16'd100, arrive_need: 8'd2,
                     leave_need: 8'd3, stay_max: 16'd3, bat_ref: 10'd0});
      repeat (10) add_tick(16'd0, 10'd79, 1'b0, blank_outcome);
      repeat (2) add_tick(16'd0, 10'd0, 1'b0, blank_outcome);
      // Battery exactly on the edge of the window keeps the valve shut, and the
      // stay timeout then sends a close pulse while already closed.
      add_settings('{high_thr: 16'd1000, low_thr: 16'd100, arrive_need: 8'd1,
                     leave_need: 8'd3, stay_max: 16'd2, bat_ref: 10'd1023});
      repeat (2) add_tick(16'hFFFF, 10'd943, 1'b0, blank_outcome);
      add_tick(16'hFFFF, 10'd1023, 1'b0, blank_outcome);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_SETTINGS)
            apply_settings(directed_rows[i].settings);
         else
            push_tick(directed_rows[i].ps, directed_rows[i].bat,
                      directed_rows[i].typed, directed_rows[i].outcome);
      end

      // Random phases, each with its own settings and idling pattern. The
      // block keeps its presence state across phases; only registers change.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         apply_settings(phase_settings(p));
         idle_mode = idle_mode_type'(p % 4);
         run_phase(p, PHASE_ITEMS);
      end

      wait_drained();
      idle_mode = IDLE_NONE;
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire
